// ===== design/windowed_vote_activation_tracker_macros.svh =====
// Assertion helpers for the tracker design file.
`ifndef WINDOWED_VOTE_ACTIVATION_TRACKER_MACROS_SVH
`define WINDOWED_VOTE_ACTIVATION_TRACKER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define VAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define VAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vat_pkg.sv =====
package vat_pkg;

  typedef struct packed {
    logic [31:0] block_height;
    logic        has_vote;
    logic [31:0] voted_version;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] effective_version;
    logic [31:0] active_version;
    logic [31:0] scheduled_version;
    logic [32:0] scheduled_height;
    logic [15:0] votes_in_window;
    logic [15:0] blocks_in_window;
    logic        locked_in;
  } out_beat_t;

  localparam logic [2:0] REG_ENABLE           = 3'd0;
  localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_PCT    = 3'd2;
  localparam logic [2:0] REG_MAX_VER          = 3'd3;
  localparam logic [2:0] REG_ACTIVATION_DELAY = 3'd4;
  localparam logic [2:0] REG_DISABLED_VERSION = 3'd5;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

// ===== design/vat_chan_if.sv =====
interface vat_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/windowed_vote_activation_tracker.sv =====
// Accepted input beats go to the input register, their results to the result register.
// Throughput: one beat per cycle unless the output stalls; the state loop is combinational.
// Output stall backs up into the input register, which still takes one beat while the
// result register is full.
// Reset (rst, synchronous, active high): config registers to 0, window and pending state to 0,
// active version to 1, both pipeline registers empty.
`include "windowed_vote_activation_tracker_macros.svh"

module windowed_vote_activation_tracker
  import vat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  vat_chan_if.sink    in_ch,
  vat_chan_if.source  out_ch
);

  // config
  logic        enable;
  logic [15:0] window_length;
  logic [6:0]  threshold_pct;
  logic [31:0] max_ver;
  logic [15:0] activation_delay;
  logic [31:0] disabled_version;

  // tracker state
  logic [32:0] window_begin, window_begin_next;
  logic [15:0] blocks_seen, blocks_seen_next;
  logic [15:0] votes, votes_next;
  logic [31:0] cur_ver, cur_ver_next;
  logic [31:0] pend_ver, pend_ver_next;
  logic [32:0] pend_height, pend_height_next;

  // pipeline
  logic      in_q_valid;
  in_beat_t  in_q;
  logic      out_valid;
  out_beat_t out_q;
  out_beat_t result;
  logic      advance;
  logic      fire;
  logic      cfg_write;
  logic [2:0] cfg_idx;

  // compute
  logic        track_on;
  logic [32:0] h33;
  logic [32:0] target;
  logic        reachable;
  logic [32:0] wb0;
  logic        restart;
  logic [15:0] seen1, votes1, seen2, votes2;
  logic        full;
  logic [22:0] thr_prod;
  logic [22:0] votes_x100;
  logic        lock;
  logic [31:0] pv3;
  logic [32:0] ph3;
  logic        activate;
  logic [31:0] eff;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
  endfunction

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      window_length    <= '0;
      threshold_pct    <= '0;
      max_ver          <= '0;
      activation_delay <= '0;
      disabled_version <= '0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_ENABLE:           enable           <= pwdata[0];
        REG_WINDOW_LENGTH:    window_length    <= pwdata[15:0];
        REG_THRESHOLD_PCT:    threshold_pct    <= pwdata[6:0];
        REG_MAX_VER:          max_ver          <= pwdata;
        REG_ACTIVATION_DELAY: activation_delay <= pwdata[15:0];
        REG_DISABLED_VERSION: disabled_version <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:           prdata = {31'd0, enable};
      REG_WINDOW_LENGTH:    prdata = {16'd0, window_length};
      REG_THRESHOLD_PCT:    prdata = {25'd0, threshold_pct};
      REG_MAX_VER:          prdata = max_ver;
      REG_ACTIVATION_DELAY: prdata = {16'd0, activation_delay};
      REG_DISABLED_VERSION: prdata = disabled_version;
      default:              prdata = '0;
    endcase
  end

  // handshake
  assign advance     = !out_valid || out_ch.ready;
  assign fire        = in_q_valid && advance;
  assign in_ch.ready = !in_q_valid || advance;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_q_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= result;
    end
  end

  // update for the beat in the input register
  assign track_on = enable && (window_length != 16'd0) && (threshold_pct != 7'd0)
                    && (max_ver > 32'd1);
  assign h33       = {1'b0, in_q.block_height};
  assign target    = {1'b0, cur_ver} + 33'd1;
  assign reachable = target <= {1'b0, max_ver};
  assign wb0       = (blocks_seen == 16'd0) ? h33 : window_begin;
  assign restart   = {1'b0, h33} >= ({1'b0, wb0} + 34'(window_length));
  assign seen1     = restart ? 16'd0 : blocks_seen;
  assign votes1    = restart ? 16'd0 : votes;
  assign seen2     = sat_inc(seen1);
  assign votes2    = (reachable && in_q.has_vote && ({1'b0, in_q.voted_version} >= target))
                     ? sat_inc(votes1) : votes1;
  assign full      = (pend_ver == 32'd0) && reachable && (seen2 >= window_length);
  // votes >= ceil(len*pct/100)  <=>  100*votes >= len*pct
  assign thr_prod   = 23'(window_length) * 23'(threshold_pct);
  assign votes_x100 = {1'b0, votes2, 6'd0} + {2'd0, votes2, 5'd0} + {5'd0, votes2, 2'd0};
  assign lock       = full && (votes_x100 >= thr_prod);
  assign pv3        = lock ? target[31:0] : pend_ver;
  assign ph3        = lock ? (h33 + 33'(activation_delay)) : pend_height;
  assign activate   = (pv3 != 32'd0) && (h33 >= ph3);

  always_comb begin
    window_begin_next = window_begin;
    blocks_seen_next  = blocks_seen;
    votes_next        = votes;
    cur_ver_next      = cur_ver;
    pend_ver_next     = pend_ver;
    pend_height_next  = pend_height;
    if (track_on) begin
      if (full) begin
        window_begin_next = h33 + 33'd1;
        blocks_seen_next  = 16'd0;
        votes_next        = 16'd0;
      end else begin
        window_begin_next = restart ? h33 : wb0;
        blocks_seen_next  = seen2;
        votes_next        = votes2;
      end
      if (activate) begin
        cur_ver_next     = pv3;
        pend_ver_next    = 32'd0;
        pend_height_next = 33'd0;
      end else begin
        pend_ver_next    = pv3;
        pend_height_next = ph3;
      end
    end
  end

  always_comb begin
    if (!enable) begin
      eff = disabled_version;
    end else if ((pend_ver_next != 32'd0) && (h33 >= pend_height_next)) begin
      eff = pend_ver_next;
    end else begin
      eff = cur_ver_next;
    end
    result.effective_version = eff;
    result.active_version    = cur_ver_next;
    result.scheduled_version = pend_ver_next;
    result.scheduled_height  = pend_height_next;
    result.votes_in_window   = votes_next;
    result.blocks_in_window  = blocks_seen_next;
    result.locked_in         = track_on && lock;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_begin <= '0;
      blocks_seen  <= '0;
      votes        <= '0;
      cur_ver      <= 32'd1;
      pend_ver     <= '0;
      pend_height  <= '0;
    end else if (fire) begin
      window_begin <= window_begin_next;
      blocks_seen  <= blocks_seen_next;
      votes        <= votes_next;
      cur_ver      <= cur_ver_next;
      pend_ver     <= pend_ver_next;
      pend_height  <= pend_height_next;
    end
  end

  `VAT_ASSERT_NOW(a_no_pend_no_height, pend_ver == 32'd0, pend_height == 33'd0, "pending height without pending version")
  `VAT_ASSERT_NOW(a_votes_le_blocks, 1'b1, votes <= blocks_seen, "window votes exceed window blocks")
  `VAT_ASSERT_NEXT(a_in_q_holds, in_q_valid && !advance, in_q_valid && $stable(in_q), "input register lost a stalled beat")

endmodule

// ===== sim/windowed_vote_activation_tracker_tb.sv =====
`timescale 1ns / 100ps

module windowed_vote_activation_tracker_tb
  import vat_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vat_chan_if #(.payload_t(in_beat_t))  in_ch ();
  vat_chan_if #(.payload_t(out_beat_t)) out_ch ();

  windowed_vote_activation_tracker dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // shadow config
  logic        en_r;
  logic [15:0] win_len_r;
  logic [6:0]  thr_pct_r;
  logic [31:0] max_ver_r;
  logic [15:0] dly_r;
  logic [31:0] dis_ver_r;

  // shadow tracker state
  logic [32:0] win_start;
  logic [15:0] blk_cnt;
  logic [15:0] vote_cnt;
  logic [31:0] act_ver;
  logic [31:0] pend_ver;
  logic [32:0] pend_h;

  in_beat_t  block_q[$];
  out_beat_t status_q[$];
  out_beat_t predicted;
  out_beat_t oldest;

  int err_cnt;
  int blocks_queued;
  int in_accepts;
  int out_accepts;
  int in_seen;
  int in_gap;
  int out_gap;
  int idle_mode;
  int lock_total;
  int act_total;
  int cfg_writes;
  logic [31:0] hgt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("windowed_vote_activation_tracker_tb: done, errors");
    $finish;
  end

  task automatic track_block(input in_beat_t b, output out_beat_t r);
    logic [32:0] h33;
    logic [32:0] target;
    logic        reach;
    logic        lock;
    int          need;
    h33    = {1'b0, b.block_height};
    target = {1'b0, act_ver} + 33'd1;
    reach  = target <= {1'b0, max_ver_r};
    lock   = 1'b0;
    if (en_r && win_len_r != 16'd0 && thr_pct_r != 7'd0 && max_ver_r > 32'd1) begin
      if (blk_cnt == 16'd0) win_start = h33;
      if (h33 >= win_start + {17'd0, win_len_r}) begin
        win_start = h33;
        blk_cnt   = 16'd0;
        vote_cnt  = 16'd0;
      end
      blk_cnt = (blk_cnt == CNT_MAX) ? CNT_MAX : blk_cnt + 16'd1;
      if (reach && b.has_vote && {1'b0, b.voted_version} >= target)
        vote_cnt = (vote_cnt == CNT_MAX) ? CNT_MAX : vote_cnt + 16'd1;
      if (pend_ver == 32'd0 && reach && blk_cnt >= win_len_r) begin
        need = (int'(win_len_r) * int'(thr_pct_r) + 99) / 100;
        if (int'(vote_cnt) >= need) begin
          pend_ver = target[31:0];
          pend_h   = h33 + {17'd0, dly_r};
          lock     = 1'b1;
          lock_total++;
        end
        win_start = h33 + 33'd1;
        blk_cnt   = 16'd0;
        vote_cnt  = 16'd0;
      end
      if (pend_ver != 32'd0 && h33 >= pend_h) begin
        act_ver  = pend_ver;
        pend_ver = 32'd0;
        pend_h   = 33'd0;
        act_total++;
      end
    end
    if (!en_r)
      r.effective_version = dis_ver_r;
    else if (pend_ver != 32'd0 && h33 >= pend_h)
      r.effective_version = pend_ver;
    else
      r.effective_version = act_ver;
    r.active_version    = act_ver;
    r.scheduled_version = pend_ver;
    r.scheduled_height  = pend_h;
    r.votes_in_window   = vote_cnt;
    r.blocks_in_window  = blk_cnt;
    r.locked_in         = lock;
  endtask

  task automatic check_field(input string fname, input logic [32:0] want,
                             input logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // monitor: predict on input beats, compare output beats
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        track_block(in_ch.data, predicted);
        status_q.push_back(predicted);
        in_accepts <= in_accepts + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_accepts <= out_accepts + 1;
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %0h", $time,
                   out_ch.data);
          err_cnt++;
        end else begin
          oldest = status_q.pop_front();
          check_field("effective_version", oldest.effective_version,
                      out_ch.data.effective_version);
          check_field("active_version", oldest.active_version,
                      out_ch.data.active_version);
          check_field("scheduled_version", oldest.scheduled_version,
                      out_ch.data.scheduled_version);
          check_field("scheduled_height", oldest.scheduled_height,
                      out_ch.data.scheduled_height);
          check_field("votes_in_window", oldest.votes_in_window,
                      out_ch.data.votes_in_window);
          check_field("blocks_in_window", oldest.blocks_in_window,
                      out_ch.data.blocks_in_window);
          check_field("locked_in", oldest.locked_in, out_ch.data.locked_in);
        end
      end
    end
  end

  // block event driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_seen == in_accepts) begin
        // beat still waiting for ready
      end else begin
        in_seen = in_accepts;
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (block_q.size() > 0 && idle_mode != 0 &&
                     $urandom_range(0, idle_mode == 2 ? 3 : 12) == 0) begin
          in_gap = $urandom_range(1, 9) - 1;
          in_ch.valid <= 1'b0;
        end else if (block_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= block_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 2 ? 3 : 10) == 0) begin
        out_gap = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE:           en_r      = val[0];
      REG_WINDOW_LENGTH:    win_len_r = val[15:0];
      REG_THRESHOLD_PCT:    thr_pct_r = val[6:0];
      REG_MAX_VER:          max_ver_r = val;
      REG_ACTIVATION_DELAY: dly_r     = val[15:0];
      REG_DISABLED_VERSION: dis_ver_r = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic en, input logic [15:0] wl, input logic [6:0] pct,
                            input logic [31:0] mv, input logic [15:0] dly,
                            input logic [31:0] dv);
    reg_write(REG_ENABLE, {31'd0, en});
    reg_write(REG_WINDOW_LENGTH, {16'd0, wl});
    reg_write(REG_THRESHOLD_PCT, {25'd0, pct});
    reg_write(REG_MAX_VER, mv);
    reg_write(REG_ACTIVATION_DELAY, {16'd0, dly});
    reg_write(REG_DISABLED_VERSION, dv);
  endtask

  task automatic push_block(input logic [31:0] h, input logic v, input logic [31:0] vv);
    in_beat_t b;
    b.block_height  = h;
    b.has_vote      = v;
    b.voted_version = vv;
    block_q.push_back(b);
    blocks_queued++;
  endtask

  task automatic settle();
    while (in_accepts != blocks_queued || out_accepts != blocks_queued) @(negedge clk);
  endtask

  task automatic random_blocks(input int n);
    int          k;
    int          r;
    logic [31:0] h;
    logic [31:0] vv;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 78)
        hgt = hgt + 32'd1;
      else if (r < 90)
        hgt = hgt + 32'($urandom_range(2, 3 * int'(win_len_r) + 2));
      h = (r >= 95) ? 32'($urandom) : hgt;
      r = $urandom_range(0, 9);
      if (r < 4)
        vv = $urandom;
      else if (r < 8)
        vv = 32'($urandom_range(0, 40));
      else
        vv = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      push_block(h, $urandom_range(0, 9) < 7, vv);
    end
  endtask

  initial begin
    int          ph;
    int          k;
    logic [31:0] mv;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    en_r = 1'b0; win_len_r = '0; thr_pct_r = '0;
    max_ver_r = '0; dly_r = '0; dis_ver_r = '0;
    win_start = '0; blk_cnt = '0; vote_cnt = '0;
    act_ver = 32'd1; pend_ver = '0; pend_h = '0;
    err_cnt = 0; blocks_queued = 0; in_accepts = 0; out_accepts = 0;
    in_seen = 0; in_gap = 0; out_gap = 0; idle_mode = 1;
    lock_total = 0; act_total = 0; cfg_writes = 0;
    hgt = 32'd100;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: disabled, degenerate configs, lock-in, threshold over 100, restart
    push_block(32'd0, 1'b0, 32'd0);
    push_block(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    settle();
    reg_write(REG_DISABLED_VERSION, 32'hFFFF_FFFF);
    push_block(32'd5, 1'b1, 32'd2);
    settle();
    reg_write(REG_ENABLE, 32'd1);
    push_block(32'd6, 1'b1, 32'd2);
    settle();
    reg_write(REG_WINDOW_LENGTH, 32'd2);
    push_block(32'd7, 1'b1, 32'd2);
    settle();
    reg_write(REG_THRESHOLD_PCT, 32'd50);
    reg_write(REG_MAX_VER, 32'd1);
    push_block(32'd8, 1'b1, 32'd2);
    settle();
    reg_write(REG_MAX_VER, 32'd0);
    push_block(32'd9, 1'b1, 32'd2);
    settle();
    reg_write(REG_MAX_VER, 32'hFFFF_FFFF);
    reg_write(REG_ACTIVATION_DELAY, 32'd0);
    push_block(32'd10, 1'b1, 32'd2);
    push_block(32'd11, 1'b1, 32'd2);
    settle();
    reg_write(REG_THRESHOLD_PCT, 32'd127);
    for (k = 20; k < 24; k++) push_block(32'(k), 1'b1, 32'hFFFF_FFFF);
    settle();
    reg_write(REG_WINDOW_LENGTH, 32'd3);
    reg_write(REG_THRESHOLD_PCT, 32'd100);
    reg_write(REG_ACTIVATION_DELAY, 32'd5);
    push_block(32'd30, 1'b1, 32'hFFFF_FFFF);
    push_block(32'd40, 1'b1, 32'd3);
    push_block(32'd41, 1'b1, 32'd3);
    push_block(32'd42, 1'b1, 32'd3);
    push_block(32'd45, 1'b0, 32'd0);
    push_block(32'd47, 1'b1, 32'd0);
    push_block(32'd48, 1'b1, 32'd1);
    settle();
    reg_write(REG_ENABLE, 32'd0);
    push_block(32'd50, 1'b1, 32'd9);
    settle();

    // random phases
    for (ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 3;
      mv = (ph == 2) ? 32'hFFFF_FFFF : (ph == 6) ? act_ver :
           act_ver + 32'($urandom_range(1, 30));
      if (ph == 7) hgt = 32'hFFFF_FFA0;
      set_config(ph != 4,
                 (ph == 3) ? 16'd1 : 16'($urandom_range(1, 8)),
                 (ph == 5) ? 7'd127 : (ph == 1) ? 7'd1 : 7'($urandom_range(1, 100)),
                 mv,
                 (ph == 7) ? 16'd0 : 16'($urandom_range(0, 12)),
                 $urandom);
      random_blocks(75);
      settle();
    end

    // no idling from here: lock-in near the top of the height range with the
    // longest delay, then a run of blocks at one height in a full-size window
    idle_mode = 0;
    set_config(1'b1, 16'd2, 7'd50, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    push_block(32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF);
    push_block(32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF);
    push_block(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    settle();
    reg_write(REG_WINDOW_LENGTH, 32'd65535);
    reg_write(REG_THRESHOLD_PCT, 32'd100);
    for (k = 0; k < 26; k++) push_block(32'hFFFF_FFF0, 1'b1, 32'hFFFF_FFFF);
    settle();

    repeat (20) @(posedge clk);
    if (status_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, status_q.size());
      err_cnt++;
    end
    $display("block events: %0d, results checked: %0d, config writes: %0d",
             blocks_queued, out_accepts, cfg_writes);
    $display("lock-ins predicted: %0d, activations predicted: %0d, mismatches: %0d",
             lock_total, act_total, err_cnt);
    if (err_cnt == 0) begin
      $display("windowed_vote_activation_tracker_tb: done, clean");
    end else begin
      $display("windowed_vote_activation_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/vat_pkg.sv
design/vat_chan_if.sv
design/windowed_vote_activation_tracker.sv
sim/windowed_vote_activation_tracker_tb.sv
